[hw/rtl/palette_color_encoder_defines.svh]
// Assertion macros shared by the palette color encoder checker.
`ifndef PALETTE_COLOR_ENCODER_DEFINES_SVH
`define PALETTE_COLOR_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PCE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("palette_color_encoder: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PCE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palette_color_encoder: next-cycle property failed");

`endif

[hw/rtl/pce_pkg.sv]
// Types, constants, palette table and quantizer for the palette color encoder.
package pce_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int IDX_W       = 6;
	localparam int DIST_W      = 18;

	typedef enum logic [2:0] {
		FMT_UNKNOWN  = 3'd0,
		FMT_INDEXED6 = 3'd1,
		FMT_RGB555LE = 3'd2,
		FMT_CRAM9BE  = 3'd3,
		FMT_CRAM6    = 3'd4,
		FMT_RGB444LE = 3'd5
	} fmt_t;

	typedef struct packed {
		logic              valid;
		logic [23:0]       rgb;
		logic [IDX_W-1:0]  best_idx;
		logic [DIST_W-1:0] best_dist;
	} pce_chain_t;

	localparam logic [23:0] PALETTE [NUM_ENTRIES] = '{
		24'h7C7C7C, 24'h0000FC, 24'h0000BC, 24'h4428BC, 24'h940084, 24'hA80020, 24'hA81000,
		24'h881400, 24'h503000, 24'h007800, 24'h006800, 24'h005800, 24'h004058, 24'h000000,
		24'h000000, 24'h000000, 24'hBCBCBC, 24'h0078F8, 24'h0058F8, 24'h6844FC, 24'hD800CC,
		24'hE40058, 24'hF83800, 24'hE45C10, 24'hAC7C00, 24'h00B800, 24'h00A800, 24'h00A844,
		24'h008888, 24'h000000, 24'h000000, 24'h000000, 24'hF8F8F8, 24'h3CBCFC, 24'h6888FC,
		24'h9878F8, 24'hF878F8, 24'hF85898, 24'hF87858, 24'hFCA044, 24'hF8B800, 24'hB8F818,
		24'h58D854, 24'h58F898, 24'h00E8D8, 24'h787878, 24'h000000, 24'h000000, 24'hFCFCFC,
		24'hA4E4FC, 24'hB8B8F8, 24'hD8B8F8, 24'hF8B8F8, 24'hF8A4C0, 24'hF0D0B0, 24'hFCE0A8,
		24'hF8D878, 24'hD8F878, 24'hB8F8B8, 24'hB8F8D8, 24'h00FCFC, 24'hF8D8F8, 24'h000000,
		24'h000000
	};

	// (v*m + 127) / 255 for m <= 31; x/255 = (x + (x>>8) + 1) >> 8 for x < 65535
	function automatic logic [4:0] quant(input logic [7:0] v, input logic [4:0] m);
		logic [15:0] x;
		logic [15:0] y;
		x = 16'(v) * 16'(m) + 16'd127;
		y = x + (x >> 8) + 16'd1;
		return y[12:8];
	endfunction

	function automatic logic [DIST_W-1:0] sqdiff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0]  d;
		logic [15:0] sq;
		d  = (a > b) ? a - b : b - a;
		sq = 16'(d) * 16'(d);
		return DIST_W'(sq);
	endfunction

endpackage

[hw/rtl/pce_if.sv]
// Stream and configuration interfaces of the palette color encoder.
interface pce_color_if;
	logic        valid;
	logic        ready;
	logic [23:0] color_rgb;
	modport source (output valid, output color_rgb, input ready);
	modport sink (input valid, input color_rgb, output ready);
endinterface

interface pce_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic [1:0] byte_count;
	modport source (output valid, output first_byte, output second_byte, output byte_count,
		input ready);
	modport sink (input valid, input first_byte, input second_byte, input byte_count,
		output ready);
endinterface

interface pce_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] storage_format;
	modport source (output valid, output storage_format, input ready);
	modport sink (input valid, input storage_format, output ready);
endinterface

[hw/rtl/palette_color_encoder.sv]
// Palette color encoder top level: 64-cell nearest-color search chain and packer.
// Pipeline from input transfer to result: 64 search cells, then one output register.
// Throughput: one color per cycle; the whole cell chain advances together and holds
// while a finished result waits on the output side.
// Reset: arst_n clears the storage format to unknown and all stage valid bits.
module palette_color_encoder (
	input  logic          clk,
	input  logic          arst_n,
	pce_color_if.sink     color,
	pce_code_if.source    code,
	pce_cfg_if.sink       cfg
);
	import pce_pkg::*;

	logic [2:0]  format_q;
	pce_chain_t  chain [NUM_ENTRIES+1];
	logic        en;
	logic [7:0]  pk_first, pk_second;
	logic [1:0]  pk_count;
	logic        out_valid_q;
	logic [7:0]  first_q, second_q;
	logic [1:0]  count_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_UNKNOWN;
		end else if (cfg.valid) begin
			format_q <= cfg.storage_format;
		end
	end

	// advance the chain whenever the output register is free or being drained
	assign en          = !out_valid_q || code.ready;
	assign color.ready = en;

	always_comb begin
		chain[0].valid     = color.valid;
		chain[0].rgb       = color.color_rgb;
		chain[0].best_idx  = '0;
		chain[0].best_dist = '1;
	end

	for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
		pce_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.entry_rgb (PALETTE[i]),
			.entry_idx (IDX_W'(i)),
			.chain_in  (chain[i]),
			.chain_q   (chain[i+1])
		);
	end

	pce_pack u_pack (
		.fmt         (format_q),
		.rgb         (chain[NUM_ENTRIES].rgb),
		.best_idx    (chain[NUM_ENTRIES].best_idx),
		.first_byte  (pk_first),
		.second_byte (pk_second),
		.byte_count  (pk_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain[NUM_ENTRIES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && chain[NUM_ENTRIES].valid) begin
			first_q  <= pk_first;
			second_q <= pk_second;
			count_q  <= pk_count;
		end
	end

	assign code.valid       = out_valid_q;
	assign code.first_byte  = first_q;
	assign code.second_byte = second_q;
	assign code.byte_count  = count_q;

endmodule

[hw/rtl/pce_cell.sv]
// One search cell: compares the passing color against its own palette entry.
module pce_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [23:0]          entry_rgb,
	input  logic [5:0]           entry_idx,
	input  pce_pkg::pce_chain_t  chain_in,
	output pce_pkg::pce_chain_t  chain_q
);
	import pce_pkg::*;

	logic [DIST_W-1:0] sq_sum;
	pce_chain_t        chain_d;

	always_comb begin
		sq_sum = sqdiff(entry_rgb[23:16], chain_in.rgb[23:16])
		       + sqdiff(entry_rgb[15:8], chain_in.rgb[15:8])
		       + sqdiff(entry_rgb[7:0], chain_in.rgb[7:0]);
		chain_d = chain_in;
		// strict compare keeps the lowest index on ties
		if (sq_sum < chain_in.best_dist) begin
			chain_d.best_dist = sq_sum;
			chain_d.best_idx  = entry_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= '0;
		end else if (en) begin
			chain_q <= chain_d;
		end
	end

endmodule

[hw/rtl/pce_pack.sv]
// Quantizes the channels and packs the bytes in the selected storage format.
module pce_pack (
	input  logic [2:0]  fmt,
	input  logic [23:0] rgb,
	input  logic [5:0]  best_idx,
	output logic [7:0]  first_byte,
	output logic [7:0]  second_byte,
	output logic [1:0]  byte_count
);
	import pce_pkg::*;

	logic [4:0] r5, g5, b5;
	logic [4:0] r3, g3, b3;
	logic [4:0] r2, g2, b2;
	logic [4:0] r4, g4, b4;

	always_comb begin
		r5 = quant(rgb[23:16], 5'd31);
		g5 = quant(rgb[15:8], 5'd31);
		b5 = quant(rgb[7:0], 5'd31);
		r3 = quant(rgb[23:16], 5'd7);
		g3 = quant(rgb[15:8], 5'd7);
		b3 = quant(rgb[7:0], 5'd7);
		r2 = quant(rgb[23:16], 5'd3);
		g2 = quant(rgb[15:8], 5'd3);
		b2 = quant(rgb[7:0], 5'd3);
		r4 = quant(rgb[23:16], 5'd15);
		g4 = quant(rgb[15:8], 5'd15);
		b4 = quant(rgb[7:0], 5'd15);

		first_byte  = '0;
		second_byte = '0;
		byte_count  = 2'd0;
		case (fmt_t'(fmt))
			FMT_INDEXED6: begin
				first_byte = {2'b00, best_idx};
				byte_count = 2'd1;
			end
			FMT_RGB555LE: begin
				first_byte  = {g5[2:0], r5};
				second_byte = {1'b0, b5, g5[4:3]};
				byte_count  = 2'd2;
			end
			FMT_CRAM9BE: begin
				// high byte first
				first_byte  = {4'b0000, b3[2:0], 1'b0};
				second_byte = {g3[2:0], 1'b0, r3[2:0], 1'b0};
				byte_count  = 2'd2;
			end
			FMT_CRAM6: begin
				first_byte = {2'b00, b2[1:0], g2[1:0], r2[1:0]};
				byte_count = 2'd1;
			end
			FMT_RGB444LE: begin
				first_byte  = {g4[3:0], r4[3:0]};
				second_byte = {4'b0000, b4[3:0]};
				byte_count  = 2'd2;
			end
			default: begin
				byte_count = 2'd0;
			end
		endcase
	end

endmodule

[hw/rtl/pce_checker.sv]
// Port-level checker for the palette color encoder and its bind.
`include "palette_color_encoder_defines.svh"

module pce_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] first_byte,
	input logic [7:0] second_byte,
	input logic [1:0] byte_count
);

	logic [17:0] code_bits;

	assign code_bits = {first_byte, second_byte, byte_count};

	// hold a stalled result
	`PCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_bits))

	// input side stalls only behind a blocked result
	`PCE_ASSERT_SAME(a_in_stall, !in_ready, out_valid && !out_ready)

	// single-byte and empty results carry no second byte
	`PCE_ASSERT_SAME(a_second_zero, out_valid && byte_count != 2'd2, second_byte == 8'd0)

	// single-byte codes fit in six bits
	`PCE_ASSERT_SAME(a_one_byte, out_valid && byte_count != 2'd2, first_byte[7:6] == 2'b00)

	// no code uses three bytes
	`PCE_ASSERT_SAME(a_count_range, out_valid, byte_count != 2'd3)

endmodule

bind palette_color_encoder pce_checker u_pce_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (color.valid),
	.in_ready    (color.ready),
	.out_valid   (code.valid),
	.out_ready   (code.ready),
	.first_byte  (code.first_byte),
	.second_byte (code.second_byte),
	.byte_count  (code.byte_count)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the palette color encoder: directed table, then random format phases.
module testbench;
	import pce_pkg::*;

	localparam int          ROW_COUNT    = 24;
	localparam int          PHASE_COUNT  = 13;
	localparam int          PHASE_ITEMS  = 85;
	localparam int          IDLE_LIMIT   = 3000;
	localparam int          TAIL_CYCLES  = 80;
	localparam int          HOLDOFF_LEN  = 400;
	localparam logic [2:0]  FMT_SPARE6   = 3'd6;
	localparam logic [2:0]  FMT_SPARE7   = 3'd7;

	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [1:0] byte_count;
	} code_t;

	typedef struct packed {
		logic [2:0]  fmt;
		logic [23:0] rgb;
		logic        typed;
		code_t       code;
	} color_row_t;

	localparam logic [23:0] MASTER_COLORS [64] = '{
		24'h7C7C7C, 24'h0000FC, 24'h0000BC, 24'h4428BC, 24'h940084, 24'hA80020, 24'hA81000,
		24'h881400, 24'h503000, 24'h007800, 24'h006800, 24'h005800, 24'h004058, 24'h000000,
		24'h000000, 24'h000000, 24'hBCBCBC, 24'h0078F8, 24'h0058F8, 24'h6844FC, 24'hD800CC,
		24'hE40058, 24'hF83800, 24'hE45C10, 24'hAC7C00, 24'h00B800, 24'h00A800, 24'h00A844,
		24'h008888, 24'h000000, 24'h000000, 24'h000000, 24'hF8F8F8, 24'h3CBCFC, 24'h6888FC,
		24'h9878F8, 24'hF878F8, 24'hF85898, 24'hF87858, 24'hFCA044, 24'hF8B800, 24'hB8F818,
		24'h58D854, 24'h58F898, 24'h00E8D8, 24'h787878, 24'h000000, 24'h000000, 24'hFCFCFC,
		24'hA4E4FC, 24'hB8B8F8, 24'hD8B8F8, 24'hF8B8F8, 24'hF8A4C0, 24'hF0D0B0, 24'hFCE0A8,
		24'hF8D878, 24'hD8F878, 24'hB8F8B8, 24'hB8F8D8, 24'h00FCFC, 24'hF8D8F8, 24'h000000,
		24'h000000
	};

	// Rows with typed = 0 take their expectation from the encoder model.
	localparam color_row_t DIRECTED_ROWS [ROW_COUNT] = '{
		'{FMT_UNKNOWN,  24'hFFFFFF, 1'b1, '{8'h00, 8'h00, 2'd0}},
		'{FMT_UNKNOWN,  24'h123456, 1'b1, '{8'h00, 8'h00, 2'd0}},
		'{FMT_INDEXED6, 24'h000000, 1'b1, '{8'd13, 8'h00, 2'd1}},
		'{FMT_INDEXED6, 24'hFFFFFF, 1'b1, '{8'd48, 8'h00, 2'd1}},
		'{FMT_INDEXED6, 24'h7C7C7C, 1'b1, '{8'd0,  8'h00, 2'd1}},
		'{FMT_INDEXED6, 24'h808080, 1'b0, '{8'h00, 8'h00, 2'd0}},
		'{FMT_INDEXED6, 24'hA55A3C, 1'b0, '{8'h00, 8'h00, 2'd0}},
		'{FMT_RGB555LE, 24'h000000, 1'b1, '{8'h00, 8'h00, 2'd2}},
		'{FMT_RGB555LE, 24'hFFFFFF, 1'b1, '{8'hFF, 8'h7F, 2'd2}},
		'{FMT_RGB555LE, 24'hFF0000, 1'b1, '{8'h1F, 8'h00, 2'd2}},
		'{FMT_RGB555LE, 24'h0000FF, 1'b1, '{8'h00, 8'h7C, 2'd2}},
		'{FMT_RGB555LE, 24'h818283, 1'b0, '{8'h00, 8'h00, 2'd0}},
		'{FMT_CRAM9BE,  24'h000000, 1'b1, '{8'h00, 8'h00, 2'd2}},
		'{FMT_CRAM9BE,  24'hFFFFFF, 1'b1, '{8'h0E, 8'hEE, 2'd2}},
		'{FMT_CRAM9BE,  24'h24496D, 1'b0, '{8'h00, 8'h00, 2'd0}},
		'{FMT_CRAM6,    24'h000000, 1'b1, '{8'h00, 8'h00, 2'd1}},
		'{FMT_CRAM6,    24'hFFFFFF, 1'b1, '{8'h3F, 8'h00, 2'd1}},
		'{FMT_CRAM6,    24'h55AA80, 1'b0, '{8'h00, 8'h00, 2'd0}},
		'{FMT_RGB444LE, 24'h000000, 1'b1, '{8'h00, 8'h00, 2'd2}},
		'{FMT_RGB444LE, 24'hFFFFFF, 1'b1, '{8'hFF, 8'h0F, 2'd2}},
		'{FMT_RGB444LE, 24'h0F88F7, 1'b0, '{8'h00, 8'h00, 2'd0}},
		'{FMT_SPARE6,   24'hFFFFFF, 1'b1, '{8'h00, 8'h00, 2'd0}},
		'{FMT_SPARE7,   24'hABCDEF, 1'b1, '{8'h00, 8'h00, 2'd0}},
		'{FMT_UNKNOWN,  24'h00FF00, 1'b1, '{8'h00, 8'h00, 2'd0}}
	};

	localparam logic [2:0] PHASE_FORMATS [PHASE_COUNT] = '{
		FMT_INDEXED6, FMT_RGB555LE, FMT_CRAM9BE, FMT_CRAM6, FMT_RGB444LE, FMT_UNKNOWN,
		FMT_SPARE7, FMT_SPARE6, FMT_RGB555LE, FMT_INDEXED6, FMT_RGB444LE, FMT_CRAM9BE,
		FMT_CRAM6
	};

	logic clk;
	logic arst_n;

	pce_color_if color_bus ();
	pce_code_if  code_bus ();
	pce_cfg_if   cfg_bus ();

	palette_color_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.color  (color_bus),
		.code   (code_bus),
		.cfg    (cfg_bus)
	);

	code_t      expected_codes [$];
	logic [2:0] cur_format;
	int         error_count;
	int         idle_cycles;
	bit         sink_random;
	bit         holdoff_go;
	int         holdoff_left;

	function automatic int unsigned scale_channel(input int unsigned v, input int unsigned top);
		int unsigned q;
		q = (v * top + 127) / 255;
		return (q > top) ? top : q;
	endfunction

	function automatic int unsigned nearest_entry(input logic [23:0] rgb);
		int unsigned best;
		int unsigned best_dist;
		int unsigned sq_sum;
		int          d;
		best      = 0;
		best_dist = 32'hFFFF_FFFF;
		for (int i = 0; i < 64; i++) begin
			sq_sum = 0;
			for (int ch = 0; ch < 3; ch++) begin
				d      = int'(MASTER_COLORS[i][ch*8 +: 8]) - int'(rgb[ch*8 +: 8]);
				sq_sum += d * d;
			end
			// strict compare keeps the lowest index on a tie
			if (sq_sum < best_dist) begin
				best_dist = sq_sum;
				best      = i;
			end
		end
		return best;
	endfunction

	function automatic code_t encode_color(input logic [2:0] fmt, input logic [23:0] rgb);
		code_t       c;
		int unsigned r;
		int unsigned g;
		int unsigned b;
		int unsigned w;
		r = rgb[23:16];
		g = rgb[15:8];
		b = rgb[7:0];
		c = '0;
		case (fmt)
			FMT_INDEXED6: begin
				c.first_byte = 8'(nearest_entry(rgb));
				c.byte_count = 2'd1;
			end
			FMT_RGB555LE: begin
				w = scale_channel(r, 31) | (scale_channel(g, 31) << 5)
					| (scale_channel(b, 31) << 10);
				c = '{8'(w), 8'(w >> 8), 2'd2};
			end
			FMT_CRAM9BE: begin
				w = (scale_channel(r, 7) << 1) | (scale_channel(g, 7) << 5)
					| (scale_channel(b, 7) << 9);
				c = '{8'(w >> 8), 8'(w), 2'd2};
			end
			FMT_CRAM6: begin
				w = scale_channel(r, 3) | (scale_channel(g, 3) << 2) | (scale_channel(b, 3) << 4);
				c = '{8'(w), 8'h00, 2'd1};
			end
			FMT_RGB444LE: begin
				w = scale_channel(r, 15) | (scale_channel(g, 15) << 4)
					| (scale_channel(b, 15) << 8);
				c = '{8'(w), 8'(w >> 8), 2'd2};
			end
			default: c = '0;
		endcase
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ERROR %s", $time, msg);
		error_count++;
	endtask

	task automatic offer_color(input logic [23:0] rgb, input code_t want);
		@(negedge clk);
		color_bus.valid     = 1'b1;
		color_bus.color_rgb = rgb;
		@(posedge clk);
		while (!color_bus.ready)
			@(posedge clk);
		expected_codes.push_back(want);
	endtask

	task automatic idle_color(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			color_bus.valid     = 1'b0;
			color_bus.color_rgb = 24'($urandom);
		end
	endtask

	task automatic wait_drained();
		while (expected_codes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_format(input logic [2:0] fmt);
		idle_color(1);
		wait_drained();
		@(negedge clk);
		cfg_bus.valid          = 1'b1;
		cfg_bus.storage_format = fmt;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cur_format = fmt;
		@(negedge clk);
		cfg_bus.valid          = 1'b0;
		cfg_bus.storage_format = 3'($urandom);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: always ready, a rotating stall pattern, or a long hold-off on request.
	initial begin : sink_side
		logic [31:0] pattern;
		int          pos;
		pattern       = '1;
		pos           = 0;
		holdoff_left  = 0;
		code_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holdoff_go) begin
				holdoff_left = HOLDOFF_LEN;
				holdoff_go   = 1'b0;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				code_bus.ready = 1'b0;
			end else if (!sink_random) begin
				code_bus.ready = 1'b1;
			end else begin
				if (pos == 0)
					pattern = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
				code_bus.ready = pattern[pos];
				pos = (pos + 1) % 32;
			end
		end
	end

	always @(posedge clk) begin : check_codes
		code_t want;
		if (arst_n && code_bus.valid && code_bus.ready) begin
			if (expected_codes.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: %h %h %0d",
					code_bus.first_byte, code_bus.second_byte, code_bus.byte_count));
			end else begin
				want = expected_codes.pop_front();
				if (code_bus.first_byte !== want.first_byte)
					report_mismatch($sformatf("first_byte got %h want %h",
						code_bus.first_byte, want.first_byte));
				if (code_bus.second_byte !== want.second_byte)
					report_mismatch($sformatf("second_byte got %h want %h",
						code_bus.second_byte, want.second_byte));
				if (code_bus.byte_count !== want.byte_count)
					report_mismatch($sformatf("byte_count got %0d want %0d",
						code_bus.byte_count, want.byte_count));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((color_bus.valid && color_bus.ready) || (code_bus.valid && code_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", idle_cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		color_row_t  row;
		code_t       want;
		logic [23:0] rgb;
		int          burst_left;
		bit          gappy;
		int          v;

		arst_n                 = 1'b0;
		color_bus.valid        = 1'b0;
		color_bus.color_rgb    = '0;
		cfg_bus.valid          = 1'b0;
		cfg_bus.storage_format = FMT_UNKNOWN;
		cur_format             = FMT_UNKNOWN;
		error_count            = 0;
		idle_cycles            = 0;
		sink_random            = 1'b0;
		holdoff_go             = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < ROW_COUNT; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.fmt != cur_format || i == ROW_COUNT - 1)
				write_format(row.fmt);
			want = row.typed ? row.code : encode_color(cur_format, row.rgb);
			offer_color(row.rgb, want);
			if ($urandom_range(0, 2) == 0)
				idle_color($urandom_range(1, 3));
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_format(PHASE_FORMATS[p]);
			sink_random = (p % 4 != 0);
			gappy       = (p % 3 != 1);
			burst_left  = 0;
			// fill the search chain against a stalled output
			if (p == 2) begin
				holdoff_go = 1'b1;
				gappy      = 1'b0;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 6 && n == PHASE_ITEMS / 2) begin
					idle_color(1);
					wait_drained();
				end
				if (burst_left == 0) begin
					if (gappy)
						idle_color($urandom_range(1, 12));
					burst_left = $urandom_range(1, 40);
				end
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: rgb = 24'($urandom);
					5, 6: begin
						rgb = MASTER_COLORS[$urandom_range(0, 63)];
						for (int ch = 0; ch < 3; ch++) begin
							v = int'(rgb[ch*8 +: 8]) + $urandom_range(0, 12) - 6;
							rgb[ch*8 +: 8] = (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : 8'(v);
						end
					end
					7: begin
						for (int ch = 0; ch < 3; ch++) begin
							case ($urandom_range(0, 5))
								0: rgb[ch*8 +: 8] = 8'h00;
								1: rgb[ch*8 +: 8] = 8'h01;
								2: rgb[ch*8 +: 8] = 8'h7F;
								3: rgb[ch*8 +: 8] = 8'h80;
								4: rgb[ch*8 +: 8] = 8'hFE;
								default: rgb[ch*8 +: 8] = 8'hFF;
							endcase
						end
					end
					8: rgb = {3{8'($urandom)}};
					default: begin
						rgb = '0;
						rgb[$urandom_range(0, 2)*8 +: 8] = 8'($urandom);
					end
				endcase
				offer_color(rgb, encode_color(cur_format, rgb));
				burst_left--;
			end
		end

		idle_color(1);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[palette_color_encoder.f]
+incdir+hw/rtl
hw/rtl/pce_pkg.sv
hw/rtl/pce_if.sv
hw/rtl/pce_cell.sv
hw/rtl/pce_pack.sv
hw/rtl/palette_color_encoder.sv
hw/rtl/pce_checker.sv
dv/testbench.sv
